[rtl/ampu_pkg.sv]
package ampu_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned SPEED_BITS   = 14;
  localparam int unsigned CMD_BITS     = 15;
  localparam int unsigned ACCEL_BITS   = 12;
  localparam int unsigned DDIST_BITS   = 23;
  localparam int unsigned THR_BITS     = 16;
  localparam int unsigned HTGT_BITS    = 24;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DAT_BITS = 24;

  // Square root operand: the square of a speed.
  localparam int unsigned SQ_BITS = 2 * SPEED_BITS;

  // Default parameter values.
  localparam int unsigned DEF_AXIS_COUNT = 2;
  localparam int unsigned DEF_POS_BITS   = 24;

  // Actions.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_TARGET = 2'd1;
  localparam logic [1:0] ACT_HOME   = 2'd2;
  localparam logic [1:0] ACT_STOP   = 2'd3;

  // Axis modes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SEEK  = 2'd1;
  localparam logic [1:0] MODE_FOUND = 2'd2;
  localparam logic [1:0] MODE_POS   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECEL      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DDIST      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPEED  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOME_SPEED = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOME_TGT   = 3'd7;

endpackage

[rtl/axis_motion_profile_homing_unit.sv]
// Trapezoidal position controller (AXIS_COUNT axes, two by default) with
// limit-switch homing. Each item addresses one axis: a control tick, a new
// target, a homing start or a stop, and yields exactly one result item. A
// positioning tick inside the braking distance but not within the threshold
// also passes two multiplies through one shared multiplier and a square
// root that produces one result bit per cycle; other items go straight from
// the distance state to the result. The block takes one item at a time;
// configuration writes are always ready and belong in idle periods.
module axis_motion_profile_homing_unit #(
  parameter int unsigned AXIS_COUNT = ampu_pkg::DEF_AXIS_COUNT,
  parameter int unsigned POS_BITS   = ampu_pkg::DEF_POS_BITS,
  parameter int unsigned AXIS_W     = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ampu_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ampu_pkg::CFG_DAT_BITS-1:0]    cfg_data_i,
  // Input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic [AXIS_W-1:0]                    axis_index_i,
  input  logic signed [POS_BITS-1:0]           measured_position_i,
  input  logic signed [ampu_pkg::CMD_BITS-1:0] measured_speed_i,
  input  logic                                 limit_level_i,
  input  logic signed [POS_BITS-1:0]           new_target_i,
  // Result items
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [AXIS_W-1:0]                    axis_out_o,
  output logic                                 speed_write_o,
  output logic signed [ampu_pkg::CMD_BITS-1:0] speed_command_o,
  output logic                                 zero_position_o,
  output logic [1:0]                           mode_out_o
);
  import ampu_pkg::*;

  localparam int unsigned DW = (POS_BITS + 1 > 24) ? POS_BITS + 1 : 24;
  localparam int unsigned PW = SPEED_BITS + DDIST_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_ARG  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers.
  logic [SPEED_BITS-1:0]        max_speed_q;
  logic [ACCEL_BITS-1:0]        accel_q;
  logic [SPEED_BITS-1:0]        decel_q;
  logic [DDIST_BITS-1:0]        ddist_q;
  logic [THR_BITS-1:0]          thr_q;
  logic [SPEED_BITS-1:0]        min_speed_q;
  logic signed [CMD_BITS-1:0]   home_speed_q;
  logic signed [HTGT_BITS-1:0]  home_tgt_q;

  assign cfg_ready_o        = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q  <= SPEED_BITS'(800);
      accel_q      <= ACCEL_BITS'(32);
      decel_q      <= SPEED_BITS'(480);
      ddist_q      <= DDIST_BITS'(656);
      thr_q        <= THR_BITS'(48);
      min_speed_q  <= SPEED_BITS'(160);
      home_speed_q <= CMD_BITS'(240);
      home_tgt_q   <= -HTGT_BITS'(160);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_SPEED:  max_speed_q  <= cfg_data_i[SPEED_BITS-1:0];
        REG_ACCEL:      accel_q      <= cfg_data_i[ACCEL_BITS-1:0];
        REG_DECEL:      decel_q      <= cfg_data_i[SPEED_BITS-1:0];
        REG_DDIST:      ddist_q      <= cfg_data_i[DDIST_BITS-1:0];
        REG_THRESHOLD:  thr_q        <= cfg_data_i[THR_BITS-1:0];
        REG_MIN_SPEED:  min_speed_q  <= cfg_data_i[SPEED_BITS-1:0];
        REG_HOME_SPEED: home_speed_q <= cfg_data_i[CMD_BITS-1:0];
        default:        home_tgt_q   <= cfg_data_i[HTGT_BITS-1:0];
      endcase
    end
  end

  // Per-axis state.
  logic [1:0]                 mode_q   [AXIS_COUNT];
  logic signed [POS_BITS-1:0] target_q [AXIS_COUNT];
  logic [SPEED_BITS-1:0]      ramp_q   [AXIS_COUNT];

  // Captured item and intermediate values.
  logic [2:0]                 state_q, state_d;
  logic [1:0]                 act_q;
  logic [AXIS_W-1:0]          axis_q;
  logic signed [POS_BITS-1:0] pos_q;
  logic signed [CMD_BITS-1:0] mspd_q;
  logic                       limit_q;
  logic signed [POS_BITS-1:0] newt_q;
  logic [POS_BITS:0]          d_q;
  logic                       neg_q;
  logic                       brake_q;
  logic                       near_q;
  logic [PW-1:0]              prod_q;
  logic [SQ_BITS-1:0]         arg_q;

  logic                       axis_ok;
  logic [1:0]                 cur_mode;
  logic signed [POS_BITS-1:0] cur_tgt;
  logic [SPEED_BITS-1:0]      cur_ramp;
  logic signed [POS_BITS:0]   delta;
  logic [POS_BITS:0]          d_abs;
  logic [DW-1:0]              d_ext;
  logic [DW-1:0]              gap;
  logic [SPEED_BITS-1:0]      mul_a;
  logic [DDIST_BITS-1:0]      mul_b;
  logic [PW-1:0]              mul_p;
  logic [PW:0]                twice;
  logic                       sq_start;
  logic                       sq_busy;
  logic [SPEED_BITS-1:0]      curve;

  assign axis_ok  = (32'(axis_q) < AXIS_COUNT);
  assign cur_mode = mode_q[axis_q];
  assign cur_tgt  = target_q[axis_q];
  assign cur_ramp = ramp_q[axis_q];

  // Distance to target and its magnitude.
  assign delta = $signed({cur_tgt[POS_BITS-1], cur_tgt})
               - $signed({pos_q[POS_BITS-1], pos_q});
  assign d_abs = delta[POS_BITS] ? (POS_BITS+1)'(-delta) : (POS_BITS+1)'(delta);
  assign d_ext = DW'(d_q);
  assign gap   = DW'(ddist_q) - d_ext;

  // Shared multiplier: braking product, then the speed cap squared.
  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = decel_q;
      mul_b = gap[DDIST_BITS-1:0];
    end else begin
      mul_a = max_speed_q;
      mul_b = DDIST_BITS'(max_speed_q);
    end
  end
  assign mul_p = mul_a * mul_b;
  assign twice = {prod_q, 1'b0};

  assign sq_start = (state_q == S_ARG);

  ampu_isqrt #(
    .W(SQ_BITS)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .arg_i  (arg_q),
    .busy_o (sq_busy),
    .root_o (curve)
  );

  // Result of the item, formed in the final state.
  logic                       out_free;
  logic                       commit;
  logic [1:0]                 new_mode;
  logic signed [POS_BITS-1:0] new_tgt;
  logic [SPEED_BITS-1:0]      new_ramp;
  logic                       wr;
  logic                       zero;
  logic signed [CMD_BITS-1:0] cmd;
  logic [CMD_BITS-1:0]        ms_abs;
  logic [CMD_BITS-1:0]        r_up;
  logic [CMD_BITS-1:0]        r_cap;
  logic [SPEED_BITS-1:0]      r_new;
  logic [SPEED_BITS-1:0]      mag;

  assign out_free = !out_valid_o || !out_stall_i;
  assign commit   = (state_q == S_DONE) && out_free;

  always_comb begin
    ms_abs = mspd_q[CMD_BITS-1] ? CMD_BITS'(-mspd_q) : CMD_BITS'(mspd_q);
    r_up   = CMD_BITS'(cur_ramp) + CMD_BITS'(accel_q);
    r_cap  = r_up;
    r_new  = cur_ramp;
    if (brake_q) begin
      if (CMD_BITS'(curve) > ms_abs) begin
        if (r_cap > CMD_BITS'(curve)) r_cap = CMD_BITS'(curve);
        if (r_cap > CMD_BITS'(max_speed_q)) r_cap = CMD_BITS'(max_speed_q);
        r_new = r_cap[SPEED_BITS-1:0];
      end else begin
        r_new = curve;
      end
    end else if (cur_ramp < max_speed_q) begin
      if (r_cap > CMD_BITS'(max_speed_q)) r_cap = CMD_BITS'(max_speed_q);
      r_new = r_cap[SPEED_BITS-1:0];
    end
    mag = (r_new < min_speed_q) ? min_speed_q : r_new;

    new_mode = cur_mode;
    new_tgt  = cur_tgt;
    new_ramp = cur_ramp;
    wr       = 1'b0;
    zero     = 1'b0;
    cmd      = '0;
    unique case (act_q)
      ACT_TARGET: begin
        new_mode = MODE_POS;
        new_tgt  = newt_q;
        new_ramp = '0;
      end
      ACT_HOME: begin
        new_mode = MODE_SEEK;
      end
      ACT_STOP: begin
        new_mode = MODE_OFF;
        wr       = 1'b1;
      end
      default: begin
        unique case (cur_mode)
          MODE_SEEK: begin
            wr  = 1'b1;
            cmd = home_speed_q;
            if (!limit_q) new_mode = MODE_FOUND;
          end
          MODE_FOUND: begin
            zero     = 1'b1;
            new_tgt  = POS_BITS'(home_tgt_q);
            new_ramp = '0;
            new_mode = MODE_POS;
          end
          MODE_POS: begin
            wr = 1'b1;
            if (!near_q) begin
              new_ramp = r_new;
              cmd      = neg_q ? -$signed(CMD_BITS'(mag)) : $signed(CMD_BITS'(mag));
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DIST;
      S_DIST: begin
        if ((act_q == ACT_TICK) && (cur_mode == MODE_POS) && axis_ok
            && (DW'(d_abs) >= DW'(thr_q)) && (DW'(d_abs) < DW'(ddist_q))) begin
          state_d = S_MUL1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_ARG;
      S_ARG:  state_d = S_ROOT;
      S_ROOT: if (!sq_busy) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        mode_q[i]   <= MODE_OFF;
        target_q[i] <= '0;
        ramp_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit && axis_ok) begin
        mode_q[axis_q]   <= new_mode;
        target_q[axis_q] <= new_tgt;
        ramp_q[axis_q]   <= new_ramp;
      end
    end
  end

  // Item capture, datapath registers and the result register.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      act_q   <= action_i;
      axis_q  <= axis_index_i;
      pos_q   <= measured_position_i;
      mspd_q  <= measured_speed_i;
      limit_q <= limit_level_i;
      newt_q  <= new_target_i;
    end
    if (state_q == S_DIST) begin
      neg_q   <= delta[POS_BITS];
      d_q     <= d_abs;
      near_q  <= (DW'(d_abs) < DW'(thr_q));
      brake_q <= (DW'(d_abs) < DW'(ddist_q));
    end
    if (state_q == S_MUL1) prod_q <= mul_p;
    if (commit) begin
      axis_out_o      <= axis_q;
      speed_write_o   <= axis_ok & wr;
      speed_command_o <= axis_ok ? cmd : '0;
      zero_position_o <= axis_ok & zero;
      mode_out_o      <= axis_ok ? new_mode : MODE_OFF;
    end
  end

  // Braking curve argument, clamped at zero.
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL2) begin
      arg_q <= (twice > (PW+1)'(mul_p[SQ_BITS-1:0])) ? '0
             : SQ_BITS'((PW+1)'(mul_p[SQ_BITS-1:0]) - twice);
    end
  end

endmodule

[rtl/ampu_isqrt.sv]
module ampu_isqrt #(
  parameter int unsigned W = 28
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   arg_i,
  output logic           busy_o,
  output logic [W/2-1:0] root_o
);

  localparam int unsigned RW = W / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [W-1:0]    x_q, x_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  // One result bit per cycle, restoring digit-by-digit square root.
  assign rem_sh = {rem_q[RW-1:0], x_q[W-1:W-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      x_d    = arg_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d    = {x_q[W-3:0], 2'b00};
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[RW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule
